/* hdl/s2cd_pkg.sv */
// Constants and helper functions for the seconds-to-calendar-date converter.
package s2cd_pkg;

  localparam int SECS_W   = 32;
  localparam int DAYS_W   = 16;
  localparam int SOD_W    = 17;
  localparam int SOH_W    = 12;
  localparam int YEAR_W   = 11;
  localparam int NSTAGE   = 6;

  // days = (secs >> 7) / 675, with 675 * 2^7 = 86400
  localparam int          DAY_SHIFT  = 35;
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [16:0] SECS_DAY   = 17'd86400;

  // Day count shifted to 1896-03-01 so that every fourth year is a leap year;
  // from 1 March 1900 on it carries one more day for the 29 February that 1900 lacks
  localparam logic [15:0] DAY_OFFSET = 16'd1402;
  localparam logic [15:0] MAR_1900   = 16'd59;
  localparam int          CYC_SHIFT  = 27;
  localparam logic [16:0] CYC_RECIP  = 17'd91868;
  localparam logic [10:0] DAYS_CYC   = 11'd1461;
  localparam logic [10:0] BASE_YEAR  = 11'd1896;

  // hour = (sod >> 4) / 225
  localparam int          HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [11:0] SECS_HOUR  = 12'd3600;

  // minute = (soh >> 2) / 15
  localparam int          MIN_SHIFT  = 14;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam logic [5:0]  SECS_MIN   = 6'd60;

  typedef struct packed {
    logic       yinc;
    logic [3:0] month;
    logic [4:0] day;
  } month_day_t;

  // First day of each month in a year that starts on 1 March
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] s;
    unique case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic month_day_t split_month(input logic [8:0] doy);
    month_day_t res;
    logic [3:0] mi;
    logic [8:0] rel;
    mi = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(4'(i))) mi = mi + 4'd1;
    end
    rel = doy - month_start(mi);
    res.day = rel[4:0] + 5'd1;
    // January and February belong to the next calendar year
    res.yinc  = (mi >= 4'd10);
    res.month = (mi >= 4'd10) ? mi - 4'd9 : mi + 4'd3;
    return res;
  endfunction

  // x mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] x);
    logic [17:0] xp;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  s3;
    xp = {2'b00, x};
    s1 = 6'(xp[2:0]) + 6'(xp[5:3]) + 6'(xp[8:6]) + 6'(xp[11:9])
       + 6'(xp[14:12]) + 6'(xp[17:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

/* hdl/seconds_to_calendar_date.sv */
// Pipelined conversion of NTP era seconds to Gregorian date, weekday and time of day.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | in_valid, in_stall, in_epoch_seconds | in
//  result  | out_valid, out_stall, out_*_out      | out
//
// Six register stages; one transfer can enter every cycle while in_stall is low.
// The depth is set by the chain of constant-reciprocal multipliers (days,
// four-year cycle, hour, minute).
// Reset clears the stage valid bits only. A stall holds a stage only while
// it is occupied and the stage after it cannot move, so bubbles are squeezed out.
module seconds_to_calendar_date (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [s2cd_pkg::SECS_W-1:0]   in_epoch_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2cd_pkg::YEAR_W-1:0]   out_year_out,
  output logic [3:0]                    out_month_out,
  output logic [4:0]                    out_day_out,
  output logic [2:0]                    out_weekday_out,
  output logic [4:0]                    out_hour_out,
  output logic [5:0]                    out_minute_out,
  output logic [5:0]                    out_second_out
);
  import s2cd_pkg::*;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;

  // stage 1
  logic [50:0]       prod_day;
  logic [DAYS_W-1:0] days_s1_r;
  logic [SOD_W-1:0]  slo_s1_r;
  // stage 2
  logic [32:0]       prod_dsec;
  logic [DAYS_W-1:0] dp_nxt;
  logic [32:0]       prod_cyc;
  logic [SOD_W-1:0]  sod_nxt;
  logic [SOD_W-1:0]  sod_s2_r;
  logic [2:0]        wd_s2_r;
  logic [DAYS_W-1:0] dp_s2_r;
  logic [5:0]        cyc_s2_r;
  // stage 3
  logic [26:0]       prod_hour;
  logic [DAYS_W-1:0] cyc_days;
  logic [DAYS_W-1:0] rem_nxt;
  logic [SOD_W-1:0]  sod_s3_r;
  logic [2:0]        wd_s3_r;
  logic [10:0]       rem_s3_r;
  logic [5:0]        cyc_s3_r;
  logic [4:0]        hour_s3_r;
  // stage 4
  logic [1:0]        yq_nxt;
  logic [10:0]       doy_nxt;
  logic [SOD_W-1:0]  hsec;
  logic [SOD_W-1:0]  soh_nxt;
  logic [2:0]        wd_s4_r;
  logic [4:0]        hour_s4_r;
  logic [SOH_W-1:0]  soh_s4_r;
  logic [8:0]        doy_s4_r;
  logic [YEAR_W-1:0] yb_s4_r;
  // stage 5
  logic [20:0]       prod_min;
  month_day_t        md_nxt;
  logic [2:0]        wd_s5_r;
  logic [4:0]        hour_s5_r;
  logic [SOH_W-1:0]  soh_s5_r;
  logic [5:0]        min_s5_r;
  logic [YEAR_W-1:0] year_s5_r;
  logic [3:0]        month_s5_r;
  logic [4:0]        day_s5_r;
  // stage 6
  logic [SOH_W-1:0]  msec;
  logic [SOH_W-1:0]  sec_nxt;
  logic [YEAR_W-1:0] year_r;
  logic [3:0]        month_r;
  logic [4:0]        day_r;
  logic [2:0]        wd_r;
  logic [4:0]        hour_r;
  logic [5:0]        min_r;
  logic [5:0]        sec_r;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 1: whole days
  assign prod_day = 51'(in_epoch_seconds[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days_s1_r <= prod_day[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
      slo_s1_r  <= in_epoch_seconds[SOD_W-1:0];
    end
  end

  // Stage 2: second of day, weekday, four-year cycle
  assign prod_dsec = 33'(days_s1_r) * 33'(SECS_DAY);
  assign sod_nxt   = slo_s1_r - prod_dsec[SOD_W-1:0];
  // Drop the extra day for January and February 1900
  assign dp_nxt    = days_s1_r + DAY_OFFSET - 16'(days_s1_r < MAR_1900);
  assign prod_cyc  = 33'(dp_nxt) * 33'(CYC_RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sod_s2_r <= sod_nxt;
      wd_s2_r  <= mod7(days_s1_r + 16'd1);
      dp_s2_r  <= dp_nxt;
      cyc_s2_r <= prod_cyc[CYC_SHIFT+5:CYC_SHIFT];
    end
  end

  // Stage 3: day within the cycle, hour
  assign cyc_days  = 16'(cyc_s2_r) * 16'(DAYS_CYC);
  assign rem_nxt   = dp_s2_r - cyc_days;
  assign prod_hour = 27'(sod_s2_r[16:4]) * 27'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sod_s3_r  <= sod_s2_r;
      wd_s3_r   <= wd_s2_r;
      rem_s3_r  <= rem_nxt[10:0];
      cyc_s3_r  <= cyc_s2_r;
      hour_s3_r <= prod_hour[HOUR_SHIFT+4:HOUR_SHIFT];
    end
  end

  // Stage 4: year within the cycle, day of year, second of hour
  always_comb begin
    priority if (rem_s3_r >= 11'd1095) yq_nxt = 2'd3;
    else if (rem_s3_r >= 11'd730)      yq_nxt = 2'd2;
    else if (rem_s3_r >= 11'd365)      yq_nxt = 2'd1;
    else                               yq_nxt = 2'd0;
  end

  assign doy_nxt = rem_s3_r - 11'(yq_nxt) * 11'd365;
  assign hsec    = 17'(hour_s3_r) * 17'(SECS_HOUR);
  assign soh_nxt = sod_s3_r - hsec;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      wd_s4_r   <= wd_s3_r;
      hour_s4_r <= hour_s3_r;
      soh_s4_r  <= soh_nxt[SOH_W-1:0];
      doy_s4_r  <= doy_nxt[8:0];
      yb_s4_r   <= BASE_YEAR + 11'({cyc_s3_r, 2'b00}) + 11'(yq_nxt);
    end
  end

  // Stage 5: month and day, minute
  assign md_nxt   = split_month(doy_s4_r);
  assign prod_min = 21'(soh_s4_r[11:2]) * 21'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      wd_s5_r    <= wd_s4_r;
      hour_s5_r  <= hour_s4_r;
      soh_s5_r   <= soh_s4_r;
      min_s5_r   <= prod_min[MIN_SHIFT+5:MIN_SHIFT];
      year_s5_r  <= yb_s4_r + 11'(md_nxt.yinc);
      month_s5_r <= md_nxt.month;
      day_s5_r   <= md_nxt.day;
    end
  end

  // Stage 6: second, output register
  assign msec    = 12'(min_s5_r) * 12'(SECS_MIN);
  assign sec_nxt = soh_s5_r - msec;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      year_r  <= year_s5_r;
      month_r <= month_s5_r;
      day_r   <= day_s5_r;
      wd_r    <= wd_s5_r;
      hour_r  <= hour_s5_r;
      min_r   <= min_s5_r;
      sec_r   <= sec_nxt[5:0];
    end
  end

  assign out_valid       = vld_r[NSTAGE-1];
  assign out_year_out    = year_r;
  assign out_month_out   = month_r;
  assign out_day_out     = day_r;
  assign out_weekday_out = wd_r;
  assign out_hour_out    = hour_r;
  assign out_minute_out  = min_r;
  assign out_second_out  = sec_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a stage is empty");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_out < 5'd24) && (out_minute_out < 6'd60)
                  && (out_second_out < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_out >= 4'd1) && (out_month_out <= 4'd12)
                  && (out_day_out != 5'd0) && (out_weekday_out < 3'd7))
    else $error("date field out of range");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_out >= 11'd1900) && (out_year_out <= 11'd2036))
    else $error("year out of range");

endmodule
